// ----- hw/rtl/a2e_pkg.sv -----
// ----------------------------------------------------------------------------
// a2e_pkg
// Shared types, constants and the arctangent table of the axis-angle to Euler
// converter.
// ----------------------------------------------------------------------------
package a2e_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TRIG_FRACTION_BITS_DEF = 14;
  localparam int unsigned TABLE_LEN = 24;

  // Width of the x and y lanes and of the angle lane in the CORDIC row.
  localparam int unsigned CW = 34;
  localparam int unsigned ZW = 34;
  localparam int unsigned ZXW = ZW + 1;
  // Width of an angle at 2048 units per turn before it is cut to a field.
  localparam int unsigned UW = ZW - 20;

  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sh80000000);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sh40000000);

  localparam logic [1:0] POLE_GENERAL = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81
  };

  // One operation travelling down the CORDIC row.
  typedef struct packed {
    logic valid;
    logic rot;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef enum logic [1:0] {
    J_POLE,
    J_HEAD,
    J_ATT,
    J_BANK
  } job_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROT,
    S_ROT_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_MUL_D,
    S_PMUL,
    S_VSEL,
    S_VPREP,
    S_NORM,
    S_VWAIT,
    S_VFIN,
    S_SQR,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/a2e_item_if.sv -----
// ----------------------------------------------------------------------------
// a2e_item_if
// Input channel: one rotation axis and angle step per transfer.
// ----------------------------------------------------------------------------
interface a2e_item_if;
  logic valid;
  logic ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] angle_step;

  modport source (output valid, axis_x, axis_y, axis_z, angle_step, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, angle_step, output ready);
endinterface

// ----- hw/rtl/a2e_result_if.sv -----
// ----------------------------------------------------------------------------
// a2e_result_if
// Output channel: heading, attitude, bank and pole case per transfer.
// ----------------------------------------------------------------------------
interface a2e_result_if;
  logic valid;
  logic ready;
  logic signed [12:0] heading;
  logic signed [10:0] attitude;
  logic signed [11:0] bank;
  logic [1:0] pole_case;

  modport source (output valid, heading, attitude, bank, pole_case, input ready);
  modport sink (input valid, heading, attitude, bank, pole_case, output ready);
endinterface

// ----- hw/rtl/a2e_cell.sv -----
// ----------------------------------------------------------------------------
// a2e_cell
// One CORDIC micro-rotation with a fixed shift and arctangent, registered.
// ----------------------------------------------------------------------------
module a2e_cell #(
  parameter int unsigned SHIFT = 0,
  parameter logic [31:0] ANGLE = '0
) (
  input  logic             clk,
  input  logic             rst,
  input  a2e_pkg::cordic_t cin,
  output a2e_pkg::cordic_t cout
);
  import a2e_pkg::*;

  logic ccw;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] ang;
  logic vld_q;
  logic mode_q;
  logic signed [CW-1:0] x_q;
  logic signed [CW-1:0] y_q;
  logic signed [ZW-1:0] z_q;

  assign xs = cin.x >>> SHIFT;
  assign ys = cin.y >>> SHIFT;
  assign ang = ZW'(ANGLE);

  // Rotation drives the angle to zero, vectoring drives y to zero.
  assign ccw = cin.rot ? !cin.z[ZW-1] : (cin.y[CW-1] || (cin.y == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cin.valid;
    end
  end

  always_ff @(posedge clk) begin
    mode_q <= cin.rot;
    if (ccw) begin
      x_q <= cin.x - ys;
      y_q <= cin.y + xs;
      z_q <= cin.z - ang;
    end else begin
      x_q <= cin.x + ys;
      y_q <= cin.y - xs;
      z_q <= cin.z + ang;
    end
  end

  assign cout = '{valid: vld_q, rot: mode_q, x: x_q, y: y_q, z: z_q};

endmodule

// ----- hw/rtl/a2e_isqrt.sv -----
// ----------------------------------------------------------------------------
// a2e_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module a2e_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);
  import a2e_pkg::*;

  logic        busy;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bitv == 64'd1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bitv == 64'd1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = res[31:0];

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("square root done while still iterating");
  a_bit_onehot: assert property (@(posedge clk) disable iff (rst) busy |-> $onehot(bitv))
    else $error("square root trial bit lost");
`endif

endmodule

// ----- hw/rtl/a2e_seq.sv -----
// ----------------------------------------------------------------------------
// a2e_seq
// Sequencer and scalar datapath: running phase, products, pole test,
// operand preparation for the CORDIC row and the output register.
// ----------------------------------------------------------------------------
module a2e_seq #(
  parameter int unsigned TRIG_FRACTION_BITS = a2e_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  a2e_item_if.sink          item,
  a2e_result_if.source      result,
  output a2e_pkg::cordic_t  chain_in,
  input  a2e_pkg::cordic_t  chain_out,
  output logic              sq_start,
  output logic [63:0]       sq_value,
  input  logic              sq_done,
  input  logic [31:0]       sq_root
);
  import a2e_pkg::*;

  localparam int unsigned F = TRIG_FRACTION_BITS;
  localparam int unsigned SW = F + 2;
  localparam int unsigned TW = F + 3;
  localparam int unsigned PW = 16 + SW;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< F;
  localparam logic signed [63:0] ONE = 64'sd1 <<< (28 + F);
  localparam logic signed [73:0] THR = 74'sd998 <<< (28 + F);

  function automatic logic signed [UW-1:0] to_units(input logic signed [ZXW-1:0] z);
    logic signed [ZXW-1:0] b;
    b = z + (z[ZXW-1] ? ZXW'((1 << 21) - 1) : '0);
    return b[ZXW-1:21];
  endfunction

  state_t state, state_next;
  job_t job_q;

  logic [16:0] phase;
  logic half_q;
  logic rot_neg;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [SW-1:0] s_q, hs_q, hc_q;
  logic signed [TW-1:0] t_q;
  logic signed [31:0] p_xy, p_xz, p_yz, p_xx, p_yy, p_zz;
  logic signed [PW-1:0] p_zs, p_ys, p_xs, pp_y;
  logic signed [32:0] s_yz, s_xz;
  logic signed [63:0] q_xy, q_xz, q_yz, q_yzz, q_xzz, v_q;
  logic signed [63:0] hy_q, hx_q, by_q, bx_q;
  logic signed [30:0] v30_q;
  logic signed [61:0] sq_q;
  logic [1:0] pole_q;
  logic signed [63:0] vx_q, vy_q, nx, ny;
  logic [63:0] nm;
  logic signed [ZW-1:0] zb_q, vz_q;
  logic signed [UW-1:0] head_q, att_q, bank_q;
  logic res_valid;
  logic signed [12:0] res_heading;
  logic signed [10:0] res_attitude;
  logic signed [11:0] res_bank;
  logic [1:0] res_pole;

  // Combinational helpers.
  logic [31:0] rot_a;
  logic signed [ZW-1:0] za, zf;
  logic fold_neg;
  logic signed [CW-1:0] xr, yr, xsh, ysh;
  logic signed [SW-1:0] cf, sf;
  logic signed [31+TW:0] m_xy, m_xz, m_yz;
  logic signed [32+TW:0] m_yzz, m_xzz;
  logic signed [73:0] v_ext, v1000;
  logic north, south;
  logic signed [63:0] v_sh;
  logic signed [61:0] m_sq;
  logic signed [63:0] sel_x, sel_y;
  logic vzero;
  logic [63:0] xa, ya;
  logic norm_hi, norm_lo;
  logic signed [ZXW-1:0] zx, zd;
  logic signed [UW-1:0] u_plain, u_pole;
  logic out_free;

  assign item.ready = (state == S_IDLE);
  assign out_free = !res_valid || result.ready;

  // Rotation angle: the full angle for the first pass, half of it at a pole.
  assign rot_a = half_q ? {phase, 15'd0} : {phase[15:0], 16'd0};
  assign za = ZW'($signed(rot_a));
  always_comb begin
    zf = za;
    fold_neg = 1'b0;
    if (za > QUARTER_TURN) begin
      zf = za - HALF_TURN;
      fold_neg = 1'b1;
    end else if (za < -QUARTER_TURN) begin
      zf = za + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  assign xr = rot_neg ? -chain_out.x : chain_out.x;
  assign yr = rot_neg ? -chain_out.y : chain_out.y;
  assign xsh = xr >>> (30 - F);
  assign ysh = yr >>> (30 - F);
  assign cf = xsh[SW-1:0];
  assign sf = ysh[SW-1:0];

  assign m_xy = p_xy * t_q;
  assign m_xz = p_xz * t_q;
  assign m_yz = p_yz * t_q;
  assign m_yzz = s_yz * t_q;
  assign m_xzz = s_xz * t_q;

  // 1000 * v as shifts and subtractions.
  assign v_ext = 74'(v_q);
  assign v1000 = (v_ext <<< 10) - (v_ext <<< 4) - (v_ext <<< 3);
  assign north = v1000 > THR;
  assign south = v1000 < -THR;
  assign v_sh = v_q >>> (F - 2);
  assign m_sq = v30_q * v30_q;

  always_comb begin
    case (job_q)
      J_POLE: begin
        sel_y = 64'(pp_y);
        sel_x = 64'(hc_q) <<< 14;
      end
      J_HEAD: begin
        sel_y = hy_q;
        sel_x = hx_q;
      end
      J_ATT: begin
        sel_y = 64'(v30_q);
        sel_x = 64'(sq_root);
      end
      J_BANK: begin
        sel_y = by_q;
        sel_x = bx_q;
      end
      default: begin
        sel_y = '0;
        sel_x = '0;
      end
    endcase
  end

  assign vzero = (vx_q == '0) && (vy_q == '0);
  assign xa = vx_q[63] ? 64'(-vx_q) : 64'(vx_q);
  assign ya = vy_q[63] ? 64'(-vy_q) : 64'(vy_q);
  assign norm_hi = nm >= (64'd1 << 30);
  assign norm_lo = nm < (64'd1 << 29);

  assign zx = {vz_q[ZW-1], vz_q};
  assign zd = {vz_q, 1'b0};
  assign u_plain = to_units(zx);
  assign u_pole = to_units((pole_q == POLE_SOUTH) ? -zd : zd);

  assign sq_value = (64'd1 << 60) - 64'(sq_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    chain_in = '0;
    sq_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        chain_in = '{valid: 1'b1, rot: 1'b1, x: GAIN_Q30, y: '0, z: zf};
        state_next = S_ROT_WAIT;
      end
      S_ROT_WAIT: begin
        if (chain_out.valid) begin
          state_next = half_q ? S_PMUL : S_MUL_A;
        end
      end
      S_MUL_A: state_next = S_MUL_B;
      S_MUL_B: state_next = S_MUL_C;
      S_MUL_C: state_next = S_MUL_D;
      S_MUL_D: begin
        state_next = (north || south) ? S_ROT : S_VSEL;
      end
      S_PMUL: state_next = S_VSEL;
      S_VSEL: state_next = S_VPREP;
      S_VPREP: begin
        state_next = vzero ? S_VFIN : S_NORM;
      end
      S_NORM: begin
        if (!norm_hi && !norm_lo) begin
          chain_in = '{valid: 1'b1, rot: 1'b0, x: nx[CW-1:0], y: ny[CW-1:0], z: zb_q};
          state_next = S_VWAIT;
        end
      end
      S_VWAIT: begin
        if (chain_out.valid) begin
          state_next = S_VFIN;
        end
      end
      S_VFIN: begin
        case (job_q)
          J_POLE: state_next = S_DONE;
          J_HEAD: state_next = S_SQR;
          J_ATT: state_next = S_VSEL;
          J_BANK: state_next = S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_SQR: state_next = S_SQRT_GO;
      S_SQRT_GO: begin
        sq_start = 1'b1;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sq_done) begin
          state_next = S_VSEL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Running phase and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      res_valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        phase <= phase + 17'(item.angle_step);
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ax_q <= item.axis_x;
        ay_q <= item.axis_y;
        az_q <= item.axis_z;
        half_q <= 1'b0;
      end
      S_ROT: begin
        rot_neg <= fold_neg;
      end
      S_ROT_WAIT: begin
        if (chain_out.valid) begin
          if (half_q) begin
            hs_q <= sf;
            hc_q <= cf;
          end else begin
            s_q <= sf;
            t_q <= T_ONE - TW'(cf);
          end
        end
      end
      S_MUL_A: begin
        p_xy <= ax_q * ay_q;
        p_xz <= ax_q * az_q;
        p_yz <= ay_q * az_q;
        p_xx <= ax_q * ax_q;
        p_yy <= ay_q * ay_q;
        p_zz <= az_q * az_q;
        p_zs <= az_q * s_q;
        p_ys <= ay_q * s_q;
        p_xs <= ax_q * s_q;
      end
      S_MUL_B: begin
        q_xy <= 64'(m_xy);
        q_xz <= 64'(m_xz);
        q_yz <= 64'(m_yz);
        s_yz <= 33'(p_yy) + 33'(p_zz);
        s_xz <= 33'(p_xx) + 33'(p_zz);
      end
      S_MUL_C: begin
        v_q <= q_xy + (64'(p_zs) <<< 14);
        q_yzz <= 64'(m_yzz);
        q_xzz <= 64'(m_xzz);
      end
      S_MUL_D: begin
        hy_q <= (64'(p_ys) <<< 14) - q_xz;
        hx_q <= ONE - q_yzz;
        by_q <= (64'(p_xs) <<< 14) - q_yz;
        bx_q <= ONE - q_xzz;
        v30_q <= v_sh[30:0];
        job_q <= J_HEAD;
        if (north) begin
          pole_q <= POLE_NORTH;
          half_q <= 1'b1;
        end else if (south) begin
          pole_q <= POLE_SOUTH;
          half_q <= 1'b1;
        end else begin
          pole_q <= POLE_GENERAL;
        end
      end
      S_PMUL: begin
        pp_y <= ax_q * hs_q;
        job_q <= J_POLE;
      end
      S_VSEL: begin
        vx_q <= sel_x;
        vy_q <= sel_y;
      end
      S_VPREP: begin
        nm <= (xa > ya) ? xa : ya;
        if (vzero) begin
          vz_q <= '0;
        end
        // A vector in the left half-plane is turned by half a turn first.
        if (vx_q[63]) begin
          nx <= -vx_q;
          ny <= -vy_q;
          zb_q <= vy_q[63] ? -HALF_TURN : HALF_TURN;
        end else begin
          nx <= vx_q;
          ny <= vy_q;
          zb_q <= '0;
        end
      end
      S_NORM: begin
        // The magnitude is tracked on its own, as flooring shifts of a
        // negative component may round it away from half the old value.
        if (norm_hi) begin
          nx <= nx >>> 1;
          ny <= ny >>> 1;
          nm <= nm >> 1;
        end else if (norm_lo) begin
          nx <= nx <<< 1;
          ny <= ny <<< 1;
          nm <= nm << 1;
        end
      end
      S_VWAIT: begin
        if (chain_out.valid) begin
          vz_q <= chain_out.z;
        end
      end
      S_VFIN: begin
        case (job_q)
          J_POLE: begin
            head_q <= u_pole;
            att_q <= (pole_q == POLE_NORTH) ? UW'(512) : -UW'(512);
            bank_q <= '0;
          end
          J_HEAD: head_q <= u_plain;
          J_ATT: begin
            att_q <= u_plain;
            job_q <= J_BANK;
          end
          J_BANK: bank_q <= u_plain;
          default: bank_q <= '0;
        endcase
      end
      S_SQR: begin
        sq_q <= m_sq;
      end
      S_SQRT_WAIT: begin
        if (sq_done) begin
          job_q <= J_ATT;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_heading <= head_q[12:0];
          res_attitude <= att_q[10:0];
          res_bank <= bank_q[11:0];
          res_pole <= pole_q;
        end
      end
      default: begin
        half_q <= half_q;
      end
    endcase
  end

  assign result.valid = res_valid;
  assign result.heading = res_heading;
  assign result.attitude = res_attitude;
  assign result.bank = res_bank;
  assign result.pole_case = res_pole;

`ifndef SYNTHESIS
  a_chain_expected: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> (state == S_ROT_WAIT || state == S_VWAIT))
    else $error("CORDIC row delivered an unexpected result");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == S_ROT && !half_q))
    else $error("accepted item did not start the full-angle rotation");
  a_pole_bank: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.pole_case != POLE_GENERAL) |-> (result.bank == '0))
    else $error("non-zero bank at a pole");
  a_sqrt_expected: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQRT_WAIT)
    else $error("square root finished outside its wait state");
`endif

endmodule

// ----- hw/rtl/axis_angle_to_euler_core.sv -----
// ----------------------------------------------------------------------------
// axis_angle_to_euler_core
// Converts a unit rotation axis and a running angle into heading, attitude
// and bank at 2048 units per turn.
// ----------------------------------------------------------------------------
// Each transfer adds its angle step to a running phase (two turns wide) and
// yields one result. All sine, cosine and arctangent work runs through one
// row of CORDIC_STEPS cells that carries one operation at a time, so an item
// takes its steps sequentially: acceptance and a rotation pass, the product
// states S_MUL_A to S_MUL_D, then either a pole case (a second rotation pass,
// the product state S_PMUL and one arctangent) or the general case (three
// arctangents plus a square root). Every arctangent of a non-zero vector
// first scales its operands one bit at a time until they fill 30 bits,
// then passes through the row. A new item is taken as soon as the
// previous result has moved into the output register.
module axis_angle_to_euler_core #(
  parameter int unsigned CORDIC_STEPS = a2e_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned TRIG_FRACTION_BITS = a2e_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  a2e_item_if.sink     item,
  a2e_result_if.source result
);
  import a2e_pkg::*;

  cordic_t link [0:CORDIC_STEPS];
  logic        sq_start;
  logic [63:0] sq_value;
  logic        sq_done;
  logic [31:0] sq_root;

  a2e_seq #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .result   (result),
    .chain_in (link[0]),
    .chain_out(link[CORDIC_STEPS]),
    .sq_start (sq_start),
    .sq_value (sq_value),
    .sq_done  (sq_done),
    .sq_root  (sq_root)
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    a2e_cell #(
      .SHIFT(i),
      .ANGLE(ATAN_TAB[i])
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .cin (link[i]),
      .cout(link[i+1])
    );
  end

  a2e_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .value(sq_value),
    .done (sq_done),
    .root (sq_root)
  );

endmodule

// ----- sim/axis_angle_to_euler_core_tb.sv -----
// ----------------------------------------------------------------------------
// axis_angle_to_euler_core_tb
// Self-checking bench for the axis-angle to Euler converter. A built-in
// fixed-point predictor follows the running phase and the CORDIC arithmetic,
// and a scoreboard compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_to_euler_core_tb;
  import a2e_pkg::*;

  localparam int NUM_RANDOM = 1630;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int FRAC = TRIG_FRACTION_BITS_DEF;

  typedef struct packed {
    logic signed [12:0] heading;
    logic signed [10:0] attitude;
    logic signed [11:0] bank;
    logic [1:0] pole_case;
  } euler_t;

  // Arithmetic shift right, rounding towards minus infinity.
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void rot_sin_cos(logic [31:0] ang, output longint sv,
                                      output longint cv);
    longint z, x, y, nx;
    bit neg;
    z = longint'($signed(ang));
    neg = 0;
    x = 652032874;
    y = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; neg = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + sra(y, i); y = y - sra(x, i); z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    cv = sra(x, 30 - FRAC);
    sv = sra(y, 30 - FRAC);
  endfunction

  function automatic longint vec_angle(longint yi, longint xi);
    longint z, m, x, y, nx;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
      x = -x; y = -y;
    end
    m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
    while (m >= (64'sd1 << 30)) begin
      x = sra(x, 1); y = sra(y, 1); m = m >> 1;
    end
    while (m < (64'sd1 << 29)) begin
      x *= 2; y *= 2; m *= 2;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (y > 0) begin
        nx = x + sra(y, i); y = y - sra(x, i); z += longint'(ATAN_TAB[i]);
      end else begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned vi);
    longint unsigned v, r, b;
    v = vi;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint to_units(longint z);
    return z / (64'sd1 << 21);
  endfunction

  class euler_scoreboard;
    logic [16:0] phase;
    euler_t pending[$];
    int errors;
    int results_seen;
    int pole_hits[3];

    function new();
      phase = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void note_item(logic signed [15:0] ax16, logic signed [15:0] ay16,
                            logic signed [15:0] az16, logic signed [15:0] st16);
      longint ax, ay, az, s, c, t, v, one, thr, hs, hc, hd, at, bk, v30;
      longint unsigned rest;
      logic [1:0] pc;
      euler_t e;
      ax = ax16; ay = ay16; az = az16;
      phase = phase + 17'(longint'(st16));
      rot_sin_cos({phase[15:0], 16'd0}, s, c);
      t = (64'sd1 << FRAC) - c;
      one = 64'sd1 << (28 + FRAC);
      v = ax * ay * t + az * s * 16384;
      thr = 998 * one;
      at = 0;
      bk = 0;
      pc = POLE_GENERAL;
      if (1000 * v > thr || 1000 * v < -thr) begin
        rot_sin_cos({phase, 15'd0}, hs, hc);
        hd = 2 * vec_angle(ax * hs, hc * 16384);
        if (1000 * v > thr) begin
          pc = POLE_NORTH; at = 512;
        end else begin
          pc = POLE_SOUTH; at = -512; hd = -hd;
        end
        hd = to_units(hd);
      end else begin
        v30 = sra(v, FRAC - 2);
        rest = (64'd1 << 60) - longint'(v30 * v30);
        hd = to_units(vec_angle(ay * s * 16384 - ax * az * t,
                                one - (ay * ay + az * az) * t));
        at = to_units(vec_angle(v30, int_sqrt(rest)));
        bk = to_units(vec_angle(ax * s * 16384 - ay * az * t,
                                one - (ax * ax + az * az) * t));
      end
      e.heading = 13'(hd);
      e.attitude = 11'(at);
      e.bank = 12'(bk);
      e.pole_case = pc;
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(euler_t got);
      euler_t want;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      results_seen++;
      if (want.pole_case < 3) pole_hits[want.pole_case]++;
      if (got.heading !== want.heading) begin
        $error("heading: expected %0d, got %0d", want.heading, got.heading);
        errors++;
      end
      if (got.attitude !== want.attitude) begin
        $error("attitude: expected %0d, got %0d", want.attitude, got.attitude);
        errors++;
      end
      if (got.bank !== want.bank) begin
        $error("bank: expected %0d, got %0d", want.bank, got.bank);
        errors++;
      end
      if (got.pole_case !== want.pole_case) begin
        $error("pole_case: expected %0d, got %0d", want.pole_case, got.pole_case);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit timed_out;

  a2e_item_if item_ch ();
  a2e_result_if result_ch ();
  euler_scoreboard sb;

  axis_angle_to_euler_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch.sink),
    .result(result_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random back-pressure, checking on each result transfer.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result({result_ch.heading, result_ch.attitude, result_ch.bank,
                         result_ch.pole_case});
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("[axis_angle_to_euler_core] ERROR");
        $finish;
      end
    end
  end

  // Valid stays high after a transfer only when the next item follows at once.
  task automatic send_item(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] az, logic signed [15:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.axis_x <= ax;
    item_ch.axis_y <= ay;
    item_ch.axis_z <= az;
    item_ch.angle_step <= st;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(ax, ay, az, st);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Half axes with |x|+|y|+|z|=16384, a share near-pole or raw; random steps.
  task automatic send_random();
    int kind;
    int a, b;
    logic signed [15:0] ax, ay, az;
    kind = $urandom_range(9);
    if (kind < 5) begin
      a = $urandom_range(16384);
      b = $urandom_range(16384 - a);
      ax = ($urandom_range(1) ? 16'(a) : 16'(-a));
      ay = ($urandom_range(1) ? 16'(b) : 16'(-b));
      az = ($urandom_range(1) ? 16'(16384 - a - b) : 16'(a + b - 16384));
    end else if (kind < 8) begin
      // Axis close to z or to the xy diagonal, where poles are reached.
      ax = $urandom_range(2) == 0 ? 16'(11585)
                                  : 16'($urandom_range(600)) - 16'sd300;
      ay = ax == 11585 ? ($urandom_range(1) ? 16'(11585) : -16'(11585))
                       : 16'($urandom_range(600)) - 16'sd300;
      az = ax == 11585 ? 16'($urandom_range(200)) - 16'sd100
                       : ($urandom_range(1) ? 16'(16384) : -16'(16384));
    end else begin
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
    end
    send_item(ax, ay, az, 16'($urandom));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    item_ch.valid = 1'b0;
    item_ch.axis_x = '0;
    item_ch.axis_y = '0;
    item_ch.axis_z = '0;
    item_ch.angle_step = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero angle, extremes, quarter turns towards both poles.
    send_item(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_item(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
    send_item(16'sd0, 16'sd0, -16'sd16384, 16'sd0);
    send_item(16'sd16384, 16'sd0, 16'sd0, 16'sd16384);
    send_item(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
    send_item(-16'sd16384, -16'sd16384, -16'sd16384, 16'sh8000);
    send_item(16'sd11585, 16'sd11585, 16'sd0, 16'sd16384);
    send_item(16'sd11585, -16'sd11585, 16'sd0, 16'sd32767);
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_item(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    send_item(16'sd0, 16'sd0, 16'sd16384, 16'sd1);
    send_item(16'sd0, 16'sd0, 16'sd16384, -16'sd1);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd0, 16'sd16384, 16'sd32767);
    // Hold off until every result is back before the random part.
    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        send_idle_pct = 88; recv_idle_pct = 38;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (n == 0) begin
        send_idle_pct = 38; recv_idle_pct = 88;
      end
      if ((n % 200) == 100) drain();
      send_random();
    end
    drain();
    repeat (300) @(posedge clk);

    $display("Checked %0d results: %0d general, %0d north pole, %0d south pole.",
             sb.results_seen, sb.pole_hits[0], sb.pole_hits[1], sb.pole_hits[2]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[axis_angle_to_euler_core] OK");
    end else begin
      $display("[axis_angle_to_euler_core] ERROR");
    end
    $finish;
  end
endmodule
